// ===== rtl/core/line_rasterizer_two_pixels_defines.svh =====
// Assertion macros for the line rasterizer.
`ifndef LINE_RASTERIZER_TWO_PIXELS_DEFINES_SVH
`define LINE_RASTERIZER_TWO_PIXELS_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define LR2P_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define LR2P_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lr2p_pkg.sv =====
// Shared types and constants for the line rasterizer.
`timescale 1ns / 1ps

package lr2p_pkg;

   localparam int CoordW             = 7;
   localparam int ColourW            = 16;
   localparam int CountW             = CoordW + 1;
   localparam int ErrW               = CoordW + 1;
   localparam int DataW              = 48;
   localparam int DisplaySizeDefault = 128;

   typedef logic [CoordW-1:0] coord_type;

   // Magnitude and direction of one axis delta.
   typedef struct packed {
      coord_type mag;
      logic      neg;
   } delta_type;

   // Per-line values produced by the setup stage.
   typedef struct packed {
      coord_type         x0;
      coord_type         y0;
      delta_type         dx;
      delta_type         dy;
      coord_type         distance;
      logic [CountW-1:0] npts;
   } setup_type;

   // Position and error accumulator of one axis.
   typedef struct packed {
      coord_type       pos;
      logic [ErrW-1:0] err;
   } axis_state_type;

endpackage

// ===== rtl/core/lr2p_setup.sv =====
// Endpoint clamp, axis deltas, step directions and point count.
`timescale 1ns / 1ps

module lr2p_setup #(
   parameter int DISPLAY_SIZE = lr2p_pkg::DisplaySizeDefault
) (
   input  lr2p_pkg::coord_type start_x,
   input  lr2p_pkg::coord_type start_y,
   input  lr2p_pkg::coord_type end_x,
   input  lr2p_pkg::coord_type end_y,
   output lr2p_pkg::setup_type setup
);

   localparam lr2p_pkg::coord_type CoordLim = lr2p_pkg::CoordW'(DISPLAY_SIZE - 1);

   lr2p_pkg::coord_type x0, y0, x1, y1;
   lr2p_pkg::delta_type dx, dy;

   function automatic lr2p_pkg::coord_type clamp(lr2p_pkg::coord_type v);
      return (v > CoordLim) ? CoordLim : v;
   endfunction

   function automatic lr2p_pkg::delta_type delta(lr2p_pkg::coord_type a,
                                                 lr2p_pkg::coord_type b);
      lr2p_pkg::delta_type d;
      d.neg = (b < a);
      d.mag = d.neg ? (a - b) : (b - a);
      return d;
   endfunction

   always_comb begin
      x0 = clamp(start_x);
      y0 = clamp(start_y);
      x1 = clamp(end_x);
      y1 = clamp(end_y);
      dx = delta(x0, x1);
      dy = delta(y0, y1);
      setup.x0       = x0;
      setup.y0       = y0;
      setup.dx       = dx;
      setup.dy       = dy;
      setup.distance = (dx.mag > dy.mag) ? dx.mag : dy.mag;
      setup.npts     = lr2p_pkg::CountW'(setup.distance) + lr2p_pkg::CountW'(1);
   end

endmodule

// ===== rtl/core/lr2p_pair_step.sv =====
// Shared step unit: advances both axes by two points.
`timescale 1ns / 1ps

module lr2p_pair_step (
   input  lr2p_pkg::axis_state_type x_cur,
   input  lr2p_pkg::axis_state_type y_cur,
   input  lr2p_pkg::delta_type      dx,
   input  lr2p_pkg::delta_type      dy,
   input  lr2p_pkg::coord_type      distance,
   output lr2p_pkg::axis_state_type x_mid,
   output lr2p_pkg::axis_state_type y_mid,
   output lr2p_pkg::axis_state_type x_nxt,
   output lr2p_pkg::axis_state_type y_nxt
);

   // err += d; on strict overflow past distance, take distance off and step the axis.
   function automatic lr2p_pkg::axis_state_type advance(lr2p_pkg::axis_state_type cur,
                                                        lr2p_pkg::delta_type d,
                                                        lr2p_pkg::coord_type lim);
      logic [lr2p_pkg::ErrW-1:0] sum;
      lr2p_pkg::axis_state_type  nxt;
      sum     = cur.err + lr2p_pkg::ErrW'(d.mag);
      nxt.pos = cur.pos;
      nxt.err = sum;
      if (sum > lr2p_pkg::ErrW'(lim)) begin
         nxt.err = sum - lr2p_pkg::ErrW'(lim);
         nxt.pos = d.neg ? (cur.pos - lr2p_pkg::CoordW'(1))
                         : (cur.pos + lr2p_pkg::CoordW'(1));
      end
      return nxt;
   endfunction

   always_comb begin
      x_mid = advance(x_cur, dx, distance);
      y_mid = advance(y_cur, dy, distance);
      x_nxt = advance(x_mid, dx, distance);
      y_nxt = advance(y_mid, dy, distance);
   end

endmodule

// ===== rtl/core/line_rasterizer_two_pixels.sv =====
// Top level: error-accumulator line rasterizer, two pixels per result item.
// An accepted request passes through ST_SETUP, then ST_RUN registers the result items.
// One line yields ceil((distance+1)/2) result items; the pair step unit produces two
//   points per cycle whenever the output register can take them.
// A new request is accepted once the final result item of the line is registered.
// Reset (synchronous, active high) clears the sequencer and the output valid.
`timescale 1ns / 1ps
`include "line_rasterizer_two_pixels_defines.svh"

module line_rasterizer_two_pixels #(
   parameter int DISPLAY_SIZE = lr2p_pkg::DisplaySizeDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   // request: two endpoints and a colour
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // start_x[6:0], start_y[13:7], end_x[20:14], end_y[27:21], colour[43:28], zero pad
   input  logic [lr2p_pkg::DataW-1:0] req_tdata,
   // response: one pixel pair per item
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // first_x[6:0], first_y[13:7], second_x[20:14], second_y[27:21],
   // pixel_colour[43:28], zero pad
   output logic [lr2p_pkg::DataW-1:0] rsp_tdata,
   // second_valid[0]
   output logic                       rsp_tuser,
   output logic                       rsp_tlast
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN
   } state_type;

   localparam int CW = lr2p_pkg::CoordW;
   localparam int PadW = lr2p_pkg::DataW - 4 * CW - lr2p_pkg::ColourW;

   state_type state_ff, state_in;

   // request payload, captured on accept
   lr2p_pkg::coord_type            start_x_ff, start_x_in;
   lr2p_pkg::coord_type            start_y_ff, start_y_in;
   lr2p_pkg::coord_type            end_x_ff, end_x_in;
   lr2p_pkg::coord_type            end_y_ff, end_y_in;
   logic [lr2p_pkg::ColourW-1:0]   colour_ff, colour_in;

   // per-line setup and walk state
   lr2p_pkg::setup_type            setup_ff, setup_in, setup_c;
   lr2p_pkg::axis_state_type       x_ff, x_in, y_ff, y_in;
   lr2p_pkg::axis_state_type       x_mid, y_mid, x_nxt, y_nxt;
   logic [lr2p_pkg::CountW-1:0]    remain_ff, remain_in;

   // output register
   logic                           rsp_tvalid_ff, rsp_tvalid_in;
   logic [lr2p_pkg::DataW-1:0]     rsp_tdata_ff, rsp_tdata_in;
   logic                           rsp_tuser_ff, rsp_tuser_in;
   logic                           rsp_tlast_ff, rsp_tlast_in;

   logic                           out_free;
   logic                           has2;
   logic                           final_pair;
   lr2p_pkg::coord_type            second_x, second_y;

   lr2p_setup #(
      .DISPLAY_SIZE (DISPLAY_SIZE)
   ) u_setup (
      .start_x (start_x_ff),
      .start_y (start_y_ff),
      .end_x   (end_x_ff),
      .end_y   (end_y_ff),
      .setup   (setup_c)
   );

   lr2p_pair_step u_pair_step (
      .x_cur    (x_ff),
      .y_cur    (y_ff),
      .dx       (setup_ff.dx),
      .dy       (setup_ff.dy),
      .distance (setup_ff.distance),
      .x_mid    (x_mid),
      .y_mid    (y_mid),
      .x_nxt    (x_nxt),
      .y_nxt    (y_nxt)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign has2       = (remain_ff >= lr2p_pkg::CountW'(2));
   assign final_pair = (remain_ff <= lr2p_pkg::CountW'(2));
   assign second_x   = has2 ? x_mid.pos : '0;
   assign second_y   = has2 ? y_mid.pos : '0;

   always_comb begin
      state_in      = state_ff;
      start_x_in    = start_x_ff;
      start_y_in    = start_y_ff;
      end_x_in      = end_x_ff;
      end_y_in      = end_y_ff;
      colour_in     = colour_ff;
      setup_in      = setup_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      remain_in     = remain_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               start_x_in = req_tdata[CW-1:0];
               start_y_in = req_tdata[2*CW-1:CW];
               end_x_in   = req_tdata[3*CW-1:2*CW];
               end_y_in   = req_tdata[4*CW-1:3*CW];
               colour_in  = req_tdata[4*CW+lr2p_pkg::ColourW-1:4*CW];
               state_in   = ST_SETUP;
            end
         end
         ST_SETUP: begin
            // deltas and count from the clamped endpoints; accumulators start at 0
            setup_in  = setup_c;
            x_in.pos  = setup_c.x0;
            x_in.err  = '0;
            y_in.pos  = setup_c.y0;
            y_in.err  = '0;
            remain_in = setup_c.npts;
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            // one pair per cycle whenever the output register can take it
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {{PadW{1'b0}}, colour_ff, second_y, second_x,
                                y_ff.pos, x_ff.pos};
               rsp_tuser_in  = has2;
               rsp_tlast_in  = final_pair;
               x_in          = x_nxt;
               y_in          = y_nxt;
               remain_in     = final_pair ? '0 : (remain_ff - lr2p_pkg::CountW'(2));
               if (final_pair) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      start_x_ff   <= start_x_in;
      start_y_ff   <= start_y_in;
      end_x_ff     <= end_x_in;
      end_y_ff     <= end_y_in;
      colour_ff    <= colour_in;
      setup_ff     <= setup_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tlast_ff <= rsp_tlast_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         remain_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         remain_ff     <= remain_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // an accepted request always goes through setup next
   `LR2P_ASSERT_NEXT(a_accept_to_setup, clock, reset, req_tvalid && req_tready, state_ff == ST_SETUP, "accepted request did not enter setup")
   // a missing second pixel can only occur on the final item of a line
   `LR2P_ASSERT_NOW(a_odd_only_last, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tlast, "single pixel item before end of line")
   // the walk never runs with no points left
   `LR2P_ASSERT_NOW(a_run_has_points, clock, reset, state_ff == ST_RUN, remain_ff != '0, "walking with zero points left")

endmodule

// ===== verif/line_rasterizer_two_pixels_tb.sv =====
// Self-checking testbench for the two-pixel line rasterizer: directed and random lines.
`timescale 1ns / 1ps

module line_rasterizer_two_pixels_tb;

   localparam int CoordW  = lr2p_pkg::CoordW;
   localparam int ColourW = lr2p_pkg::ColourW;
   localparam int DataW   = lr2p_pkg::DataW;
   typedef lr2p_pkg::coord_type coord_type;

   // Display edge at the default size; 7-bit endpoints never reach past it,
   // so endpoint saturation never changes a coordinate here.
   localparam int Size        = lr2p_pkg::DisplaySizeDefault;
   localparam int PadW        = DataW - 4 * CoordW - ColourW;
   localparam int RandomLines = 390;
   localparam int HoldCycles  = 400;   // long receiver hold-off
   localparam int IdlePct     = 30;    // per-cycle idle odds on each side
   localparam int DrainCycles = 20;    // settle time after the last result
   localparam int MaxReports  = 10;

   // One line request.
   typedef struct packed {
      coord_type          x0;
      coord_type          y0;
      coord_type          x1;
      coord_type          y1;
      logic [ColourW-1:0] colour;
   } line_type;

   // One pixel pair as it should appear on the result bus.
   typedef struct packed {
      logic [DataW-1:0] data;
      logic             second_valid;
      logic             last;
   } pair_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [DataW-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [DataW-1:0] rsp_tdata;
   logic             rsp_tuser;
   logic             rsp_tlast;

   line_type line_queue[$];       // requests not yet offered
   pair_type pixel_pairs_due[$];  // pairs predicted, oldest first
   line_type line_on_bus;         // request currently offered
   int       lines_sent     = 0;
   int       mismatch_count = 0;
   logic     hold_off       = 1'b0;
   logic     steady;              // stretch with no idling on either side

   line_rasterizer_two_pixels dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   assign steady = (lines_sent >= 200) && (lines_sent < 260);

   function automatic void note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MaxReports) $display("%t: %s", $time, msg);
   endfunction

   // Walks the line with the error accumulators and queues its pixel pairs.
   // The accumulators step an axis only when they strictly exceed the distance,
   // so the main axis lags: the first point repeats and the far endpoint is
   // never drawn.
   function automatic void rasterize_line(line_type ln);
      int        dx, dy, sx, sy, distance, npts, err_x, err_y, px, py, t;
      coord_type xs[Size];
      coord_type ys[Size];
      pair_type  pr;
      logic      has2;
      dx = int'(ln.x1) - int'(ln.x0);
      dy = int'(ln.y1) - int'(ln.y0);
      sx = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
      sy = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      distance = (dx > dy) ? dx : dy;
      npts     = distance + 1;
      px       = ln.x0;
      py       = ln.y0;
      err_x    = 0;
      err_y    = 0;
      for (t = 0; t < npts; t++) begin
         xs[t] = px[CoordW-1:0];
         ys[t] = py[CoordW-1:0];
         err_x += dx;
         err_y += dy;
         if (err_x > distance) begin
            err_x -= distance;
            px += sx;
         end
         if (err_y > distance) begin
            err_y -= distance;
            py += sy;
         end
      end
      // two points per pair; an odd count leaves the last second pixel zero
      for (t = 0; t < npts; t += 2) begin
         has2    = (t + 1) < npts;
         pr.data = {{PadW{1'b0}}, ln.colour,
                    has2 ? ys[t+1] : coord_type'(0),
                    has2 ? xs[t+1] : coord_type'(0),
                    ys[t], xs[t]};
         pr.second_valid = has2;
         pr.last         = (t + 2) >= npts;
         pixel_pairs_due.push_back(pr);
      end
   endfunction

   // Request driver: holds an item until accepted, then offers the next one
   // or idles at random. Prediction happens at the accepting edge.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            rasterize_line(line_on_bus);
            lines_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (line_queue.size() != 0 && (steady || $urandom_range(99) >= IdlePct)) begin
               line_on_bus = line_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{PadW{1'b0}}, line_on_bus.colour, line_on_bus.y1,
                              line_on_bus.x1, line_on_bus.y0, line_on_bus.x0};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result receiver: random back-pressure, plus the long hold-off below.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !hold_off && (steady || $urandom_range(99) >= IdlePct);
      end
   end

   // Long hold-off on the result side while requests keep coming, so the
   // block backs up and has to drop req_tready.
   initial begin
      wait (lines_sent >= 60);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HoldCycles) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Result monitor: each accepted item against the oldest predicted pair.
   always @(posedge clock) begin : monitor
      pair_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_pairs_due.size() == 0) begin
            note_mismatch($sformatf("unexpected item data=%h user=%b last=%b",
                                    rsp_tdata, rsp_tuser, rsp_tlast));
         end else begin
            want = pixel_pairs_due.pop_front();
            if ({rsp_tdata, rsp_tuser, rsp_tlast} !==
                {want.data, want.second_valid, want.last}) begin
               note_mismatch($sformatf(
                  "pair mismatch: exp data=%h sv=%b last=%b, got data=%h sv=%b last=%b",
                  want.data, want.second_valid, want.last,
                  rsp_tdata, rsp_tuser, rsp_tlast));
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin : stimulus
      line_type ln;
      int       len, k;
      // directed: single points, full-length lines in every direction,
      // shallow and steep slopes with negative dy, odd and even point counts
      line_queue.push_back('{7'd0,   7'd0,   7'd0,   7'd0,   16'h0000});
      line_queue.push_back('{7'd127, 7'd127, 7'd127, 7'd127, 16'hFFFF});
      line_queue.push_back('{7'd0,   7'd0,   7'd127, 7'd0,   16'hF800});
      line_queue.push_back('{7'd127, 7'd127, 7'd0,   7'd127, 16'h07E0});
      line_queue.push_back('{7'd0,   7'd0,   7'd0,   7'd127, 16'h001F});
      line_queue.push_back('{7'd127, 7'd127, 7'd127, 7'd0,   16'hAAAA});
      line_queue.push_back('{7'd0,   7'd0,   7'd127, 7'd127, 16'h5555});
      line_queue.push_back('{7'd127, 7'd127, 7'd0,   7'd0,   16'h1234});
      line_queue.push_back('{7'd0,   7'd127, 7'd127, 7'd0,   16'hFEDC});
      line_queue.push_back('{7'd127, 7'd0,   7'd0,   7'd127, 16'h8001});
      line_queue.push_back('{7'd10,  7'd10,  7'd12,  7'd10,  16'h0F0F});  // odd count
      line_queue.push_back('{7'd5,   7'd5,   7'd6,   7'd5,   16'hF0F0});  // two points
      line_queue.push_back('{7'd5,   7'd5,   7'd5,   7'd4,   16'h3C3C});  // up by one
      line_queue.push_back('{7'd20,  7'd100, 7'd30,  7'd40,  16'hC3C3});  // steep, dy < 0
      line_queue.push_back('{7'd90,  7'd60,  7'd10,  7'd50,  16'h7FFF});  // shallow, dy < 0
      line_queue.push_back('{7'd64,  7'd64,  7'd66,  7'd65,  16'h0001});
      line_queue.push_back('{7'd3,   7'd120, 7'd100, 7'd7,   16'hFFFE});
      line_queue.push_back('{7'd126, 7'd1,   7'd1,   7'd126, 16'h4210});
      // random: mostly short lines, the rest with endpoints anywhere on the display
      for (k = 0; k < RandomLines; k++) begin
         ln.x0     = coord_type'($urandom_range(Size - 1));
         ln.y0     = coord_type'($urandom_range(Size - 1));
         ln.colour = ColourW'($urandom);
         if ($urandom_range(99) < 70) begin
            len   = $urandom_range(16);
            ln.x1 = coord_type'(int'(ln.x0) + len - 8 < 0 ? 0 :
                               (int'(ln.x0) + len - 8 > Size - 1 ? Size - 1 :
                                int'(ln.x0) + len - 8));
            len   = $urandom_range(16);
            ln.y1 = coord_type'(int'(ln.y0) + len - 8 < 0 ? 0 :
                               (int'(ln.y0) + len - 8 > Size - 1 ? Size - 1 :
                                int'(ln.y0) + len - 8));
         end else begin
            ln.x1 = coord_type'($urandom_range(Size - 1));
            ln.y1 = coord_type'($urandom_range(Size - 1));
         end
         line_queue.push_back(ln);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // every request taken, then every predicted pair seen
      while (line_queue.size() != 0 || req_tvalid) @(posedge clock);
      while (pixel_pairs_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (pixel_pairs_due.size() != 0)
         note_mismatch($sformatf("%0d pairs never arrived", pixel_pairs_due.size()));
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
